### hdl/pfsm_pkg.sv
// ----------------------------------------------------------------------------
// pfsm_pkg: shared types and codes for the playback frame state machine
// Event codes, one-hot machine states, output state codes and the status
// group that travels from the engine to the output stage.
// ----------------------------------------------------------------------------
package pfsm_pkg;

	typedef enum logic [3:0] {
		CMD_SELECT     = 4'd0,
		CMD_START      = 4'd1,
		CMD_PAUSE      = 4'd2,
		CMD_RESUME     = 4'd3,
		CMD_SEEK       = 4'd4,
		CMD_ENDED      = 4'd5,
		CMD_FAIL       = 4'd6,
		CMD_RDREADY    = 4'd7,
		CMD_RDBEGIN    = 4'd8,
		CMD_RDCOMPLETE = 4'd9,
		CMD_RDFAIL     = 4'd10,
		CMD_CANCEL     = 4'd11,
		CMD_LOOP       = 4'd12,
		CMD_FRAMETAG   = 4'd13
	} cmd_t;

	typedef enum logic [5:0] {
		PB_EMPTY   = 6'b000001,
		PB_READY   = 6'b000010,
		PB_PLAYING = 6'b000100,
		PB_PAUSED  = 6'b001000,
		PB_ENDED   = 6'b010000,
		PB_FAILED  = 6'b100000
	} pb_state_t;

	typedef enum logic [5:0] {
		RD_UNINIT    = 6'b000001,
		RD_READY     = 6'b000010,
		RD_READING   = 6'b000100,
		RD_COMPLETED = 6'b001000,
		RD_FAILED    = 6'b010000,
		RD_CANCELLED = 6'b100000
	} rd_state_t;

	localparam logic [2:0] PBC_EMPTY   = 3'd0;
	localparam logic [2:0] PBC_READY   = 3'd1;
	localparam logic [2:0] PBC_PLAYING = 3'd2;
	localparam logic [2:0] PBC_PAUSED  = 3'd3;
	localparam logic [2:0] PBC_ENDED   = 3'd4;
	localparam logic [2:0] PBC_FAILED  = 3'd5;

	localparam logic [2:0] RDC_UNINIT    = 3'd0;
	localparam logic [2:0] RDC_READY     = 3'd1;
	localparam logic [2:0] RDC_READING   = 3'd2;
	localparam logic [2:0] RDC_COMPLETED = 3'd3;
	localparam logic [2:0] RDC_FAILED    = 3'd4;
	localparam logic [2:0] RDC_CANCELLED = 3'd5;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_UNKNOWN   = 4'd1;
	localparam logic [3:0] ERR_CANCELLED = 4'd2;

	localparam int IN_BITS     = 8;
	localparam int STATUS_BITS = 13;

	typedef struct packed {
		logic       loop_allowed;
		logic       media_present;
		logic [3:0] reader_error;
		logic [2:0] reader_state;
		logic [2:0] playback_state;
		logic       accepted;
	} status_t;

	function automatic logic [2:0] pb_code(input pb_state_t s);
		logic [2:0] c;
		unique case (s)
			PB_EMPTY:   c = PBC_EMPTY;
			PB_READY:   c = PBC_READY;
			PB_PLAYING: c = PBC_PLAYING;
			PB_PAUSED:  c = PBC_PAUSED;
			PB_ENDED:   c = PBC_ENDED;
			PB_FAILED:  c = PBC_FAILED;
			default:    c = PBC_EMPTY;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] rd_code(input rd_state_t s);
		logic [2:0] c;
		unique case (s)
			RD_UNINIT:    c = RDC_UNINIT;
			RD_READY:     c = RDC_READY;
			RD_READING:   c = RDC_READING;
			RD_COMPLETED: c = RDC_COMPLETED;
			RD_FAILED:    c = RDC_FAILED;
			RD_CANCELLED: c = RDC_CANCELLED;
			default:      c = RDC_UNINIT;
		endcase
		return c;
	endfunction

endpackage

### hdl/playback_frame_state_machine_core.sv
// ----------------------------------------------------------------------------
// playback_frame_state_machine_core: playback and reader event processor
// Input register, event engine and output register for one event per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one event per item (cmd, error_code). m_* returns one result
//   item per event: accepted flag, playback and reader states, reader error,
//   media and loop flags, and the four counters.
//   An item passes from the input register through the event engine into
//   the result register. Throughput is one item per cycle while the
//   receiver does not stall; the engine's state registers are updated in
//   the same cycle that the result is captured.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more item, and s_tready drops only when both are full.
//   Reset clears both valid flags and returns the machines to empty and
//   uninitialized with all counters at zero.
// ----------------------------------------------------------------------------
module playback_frame_state_machine_core #(
	parameter int COUNTER_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// cmd[3:0], error_code[7:4]
	input  logic [7:0]           s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// accepted[0], playback_state[3:1], reader_state[6:4], reader_error[10:7],
	// media_present[11], loop_allowed[12], frame_sequence, media_generation,
	// timeline_epoch, loop_count (COUNTER_BITS each), zero pad
	output logic [((pfsm_pkg::STATUS_BITS + 4 * COUNTER_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int RAW_BITS = pfsm_pkg::STATUS_BITS + 4 * COUNTER_BITS;
	localparam int OUT_BITS = ((RAW_BITS + 7) / 8) * 8;
	localparam int PAD_BITS = OUT_BITS - RAW_BITS;

	logic                    valid_s1;
	logic [3:0]              cmd_s1;
	logic [3:0]              code_s1;
	logic                    valid_s2;
	pfsm_pkg::status_t       status_s2;
	logic [COUNTER_BITS-1:0] seq_s2, gen_s2, ep_s2, it_s2;

	logic                    advance;
	logic                    fire;
	pfsm_pkg::status_t       status_c;
	logic [COUNTER_BITS-1:0] seq_c, gen_c, ep_c, it_c;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tdata[3:0];
			code_s1 <= s_tdata[7:4];
		end
	end

	pfsm_engine #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.cmd              (cmd_s1),
		.error_code       (code_s1),
		.status           (status_c),
		.frame_sequence   (seq_c),
		.media_generation (gen_c),
		.timeline_epoch   (ep_c),
		.loop_count       (it_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_c;
			seq_s2    <= seq_c;
			gen_s2    <= gen_c;
			ep_s2     <= ep_c;
			it_s2     <= it_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{PAD_BITS{1'b0}}, it_s2, ep_s2, gen_s2, seq_s2, status_s2};

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while result register empty");

	a_loop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_s2.loop_allowed |->
			status_s2.media_present && status_s2.reader_state == pfsm_pkg::RDC_COMPLETED)
		else $error("loop allowed without media or completed reader");

	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_s2.reader_state == pfsm_pkg::RDC_FAILED |->
			status_s2.reader_error != pfsm_pkg::ERR_NONE)
		else $error("reader failed with no error code");

	a_empty_no_media: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_s2.playback_state == pfsm_pkg::PBC_EMPTY |->
			!status_s2.media_present)
		else $error("playback empty with media present");
`endif

endmodule

### hdl/pfsm_engine.sv
// ----------------------------------------------------------------------------
// pfsm_engine: playback and reader machines with their counters
// Holds the machine state and applies one event per fire; presents the
// result of the event being applied in the same cycle.
// ----------------------------------------------------------------------------
module pfsm_engine #(
	parameter int COUNTER_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  logic [3:0]              cmd,
	input  logic [3:0]              error_code,
	output pfsm_pkg::status_t       status,
	output logic [COUNTER_BITS-1:0] frame_sequence,
	output logic [COUNTER_BITS-1:0] media_generation,
	output logic [COUNTER_BITS-1:0] timeline_epoch,
	output logic [COUNTER_BITS-1:0] loop_count
);

	localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

	pfsm_pkg::pb_state_t     pb_q, pb_n;
	pfsm_pkg::rd_state_t     rd_q, rd_n;
	logic [3:0]              err_q, err_n;
	logic                    media_q, media_n;
	logic [COUNTER_BITS-1:0] gen_q, gen_n;
	logic [COUNTER_BITS-1:0] ep_q, ep_n;
	logic [COUNTER_BITS-1:0] seq_q, seq_n;
	logic [COUNTER_BITS-1:0] it_q, it_n;
	logic                    ok;
	logic                    epoch;
	logic                    is_tag;

	always_comb begin
		pb_n    = pb_q;
		rd_n    = rd_q;
		err_n   = err_q;
		media_n = media_q;
		gen_n   = gen_q;
		ep_n    = ep_q;
		seq_n   = seq_q;
		it_n    = it_q;
		ok      = 1'b0;
		epoch   = 1'b0;
		is_tag  = 1'b0;
		unique case (pfsm_pkg::cmd_t'(cmd))
			pfsm_pkg::CMD_SELECT: begin
				media_n = 1'b1;
				gen_n   = gen_q + CNT_ONE;
				it_n    = '0;
				pb_n    = pfsm_pkg::PB_READY;
				rd_n    = pfsm_pkg::RD_UNINIT;
				err_n   = pfsm_pkg::ERR_NONE;
				epoch   = 1'b1;
				ok      = 1'b1;
			end
			pfsm_pkg::CMD_START: begin
				if (media_q && (pb_q == pfsm_pkg::PB_READY || pb_q == pfsm_pkg::PB_ENDED)) begin
					pb_n  = pfsm_pkg::PB_PLAYING;
					epoch = 1'b1;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_PAUSE: begin
				if (pb_q == pfsm_pkg::PB_PLAYING) begin
					pb_n = pfsm_pkg::PB_PAUSED;
					ok   = 1'b1;
				end
			end
			pfsm_pkg::CMD_RESUME: begin
				if (pb_q == pfsm_pkg::PB_PAUSED) begin
					pb_n  = pfsm_pkg::PB_PLAYING;
					epoch = 1'b1;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_SEEK: begin
				if (media_q && pb_q != pfsm_pkg::PB_EMPTY && pb_q != pfsm_pkg::PB_FAILED) begin
					if (pb_q == pfsm_pkg::PB_ENDED) begin
						pb_n = pfsm_pkg::PB_READY;
					end
					rd_n  = pfsm_pkg::RD_UNINIT;
					err_n = pfsm_pkg::ERR_NONE;
					epoch = 1'b1;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_ENDED: begin
				if (pb_q == pfsm_pkg::PB_PLAYING || pb_q == pfsm_pkg::PB_PAUSED) begin
					pb_n = pfsm_pkg::PB_ENDED;
					ok   = 1'b1;
				end
			end
			pfsm_pkg::CMD_FAIL: begin
				pb_n = pfsm_pkg::PB_FAILED;
				ok   = 1'b1;
			end
			pfsm_pkg::CMD_RDREADY: begin
				if (rd_q == pfsm_pkg::RD_UNINIT) begin
					rd_n  = pfsm_pkg::RD_READY;
					err_n = pfsm_pkg::ERR_NONE;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_RDBEGIN: begin
				if (rd_q == pfsm_pkg::RD_READY) begin
					rd_n  = pfsm_pkg::RD_READING;
					err_n = pfsm_pkg::ERR_NONE;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_RDCOMPLETE: begin
				if (rd_q == pfsm_pkg::RD_READING) begin
					rd_n  = pfsm_pkg::RD_COMPLETED;
					err_n = pfsm_pkg::ERR_NONE;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_RDFAIL: begin
				rd_n  = pfsm_pkg::RD_FAILED;
				err_n = (error_code == pfsm_pkg::ERR_NONE) ? pfsm_pkg::ERR_UNKNOWN : error_code;
				ok    = 1'b1;
			end
			pfsm_pkg::CMD_CANCEL: begin
				rd_n  = pfsm_pkg::RD_CANCELLED;
				err_n = pfsm_pkg::ERR_CANCELLED;
				ok    = 1'b1;
			end
			pfsm_pkg::CMD_LOOP: begin
				if (media_q && rd_q == pfsm_pkg::RD_COMPLETED) begin
					it_n  = it_q + CNT_ONE;
					rd_n  = pfsm_pkg::RD_READY;
					err_n = pfsm_pkg::ERR_NONE;
					ok    = 1'b1;
				end
			end
			pfsm_pkg::CMD_FRAMETAG: begin
				seq_n  = seq_q + CNT_ONE;
				is_tag = 1'b1;
				ok     = 1'b1;
			end
			default: begin
			end
		endcase
		if (epoch) begin
			ep_n  = ep_q + CNT_ONE;
			seq_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q    <= pfsm_pkg::PB_EMPTY;
			rd_q    <= pfsm_pkg::RD_UNINIT;
			err_q   <= pfsm_pkg::ERR_NONE;
			media_q <= 1'b0;
			gen_q   <= '0;
			ep_q    <= '0;
			seq_q   <= '0;
			it_q    <= '0;
		end else if (fire) begin
			pb_q    <= pb_n;
			rd_q    <= rd_n;
			err_q   <= err_n;
			media_q <= media_n;
			gen_q   <= gen_n;
			ep_q    <= ep_n;
			seq_q   <= seq_n;
			it_q    <= it_n;
		end
	end

	assign status.accepted       = ok;
	assign status.playback_state = pfsm_pkg::pb_code(pb_n);
	assign status.reader_state   = pfsm_pkg::rd_code(rd_n);
	assign status.reader_error   = err_n;
	assign status.media_present  = media_n;
	assign status.loop_allowed   = media_n && (rd_n == pfsm_pkg::RD_COMPLETED);

	assign frame_sequence   = is_tag ? seq_q : seq_n;
	assign media_generation = gen_n;
	assign timeline_epoch   = ep_n;
	assign loop_count       = it_n;

endmodule

### tb/playback_frame_state_machine_core_test.sv
// ----------------------------------------------------------------------------
// playback_frame_state_machine_core_test: event stream check of the playback core
// Feeds directed and random playback and reader events through the input
// stream with random gaps and result stalls. A scoreboard object predicts
// the status and counters for every accepted item and compares each result.
// ----------------------------------------------------------------------------
module playback_frame_state_machine_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB         = 64;
	localparam int OUT_W      = ((pfsm_pkg::STATUS_BITS + 4 * CB + 7) / 8) * 8;
	localparam int RUN_ITEMS  = 700;
	localparam int IDLE_LIMIT = 2000;

	localparam logic [3:0] CMD_UNUSED_LO = 4'd14;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
	localparam logic [3:0] ERR_TOP       = 4'hF;

	typedef struct packed {
		logic [CB-1:0] loop_count;
		logic [CB-1:0] timeline_epoch;
		logic [CB-1:0] media_generation;
		logic [CB-1:0] frame_sequence;
		logic          loop_allowed;
		logic          media_present;
		logic [3:0]    reader_error;
		logic [2:0]    reader_state;
		logic [2:0]    playback_state;
		logic          accepted;
	} frame_status_t;

	localparam int ST_W = $bits(frame_status_t);

	class playback_tracker;
		logic [2:0]    play;
		logic [2:0]    reader;
		logic [3:0]    fault;
		logic          media;
		logic [CB-1:0] gen_cnt;
		logic [CB-1:0] epoch_cnt;
		logic [CB-1:0] seq_cnt;
		logic [CB-1:0] iter_cnt;
		frame_status_t status_due[$];
		int            mismatches;
		int            compared;
		int            taken;
		int            granted;

		function new();
			play       = pfsm_pkg::PBC_EMPTY;
			reader     = pfsm_pkg::RDC_UNINIT;
			fault      = pfsm_pkg::ERR_NONE;
			media      = 1'b0;
			gen_cnt    = '0;
			epoch_cnt  = '0;
			seq_cnt    = '0;
			iter_cnt   = '0;
			mismatches = 0;
			compared   = 0;
			taken      = 0;
			granted    = 0;
		endfunction

		function bit allows(logic [3:0] cmd);
			case (cmd)
				pfsm_pkg::CMD_SELECT, pfsm_pkg::CMD_FAIL, pfsm_pkg::CMD_RDFAIL,
				pfsm_pkg::CMD_CANCEL, pfsm_pkg::CMD_FRAMETAG:
					return 1'b1;
				pfsm_pkg::CMD_START:
					return media && (play == pfsm_pkg::PBC_READY ||
						play == pfsm_pkg::PBC_ENDED);
				pfsm_pkg::CMD_PAUSE:      return play == pfsm_pkg::PBC_PLAYING;
				pfsm_pkg::CMD_RESUME:     return play == pfsm_pkg::PBC_PAUSED;
				pfsm_pkg::CMD_SEEK:
					return media && play != pfsm_pkg::PBC_EMPTY &&
						play != pfsm_pkg::PBC_FAILED;
				pfsm_pkg::CMD_ENDED:
					return play == pfsm_pkg::PBC_PLAYING || play == pfsm_pkg::PBC_PAUSED;
				pfsm_pkg::CMD_RDREADY:    return reader == pfsm_pkg::RDC_UNINIT;
				pfsm_pkg::CMD_RDBEGIN:    return reader == pfsm_pkg::RDC_READY;
				pfsm_pkg::CMD_RDCOMPLETE: return reader == pfsm_pkg::RDC_READING;
				pfsm_pkg::CMD_LOOP:       return media && reader == pfsm_pkg::RDC_COMPLETED;
				default:                  return 1'b0;
			endcase
		endfunction

		function void restart_timeline();
			epoch_cnt++;
			seq_cnt = '0;
		endfunction

		function void take_event(logic [3:0] cmd, logic [3:0] code);
			frame_status_t s;
			bit            ok;
			ok = allows(cmd);
			taken++;
			if (ok) begin
				granted++;
				case (cmd)
					pfsm_pkg::CMD_SELECT: begin
						media    = 1'b1;
						gen_cnt++;
						iter_cnt = '0;
						play     = pfsm_pkg::PBC_READY;
						reader   = pfsm_pkg::RDC_UNINIT;
						fault    = pfsm_pkg::ERR_NONE;
						restart_timeline();
					end
					pfsm_pkg::CMD_START: begin
						play = pfsm_pkg::PBC_PLAYING;
						restart_timeline();
					end
					pfsm_pkg::CMD_PAUSE: play = pfsm_pkg::PBC_PAUSED;
					pfsm_pkg::CMD_RESUME: begin
						play = pfsm_pkg::PBC_PLAYING;
						restart_timeline();
					end
					pfsm_pkg::CMD_SEEK: begin
						if (play == pfsm_pkg::PBC_ENDED)
							play = pfsm_pkg::PBC_READY;
						reader = pfsm_pkg::RDC_UNINIT;
						fault  = pfsm_pkg::ERR_NONE;
						restart_timeline();
					end
					pfsm_pkg::CMD_ENDED: play = pfsm_pkg::PBC_ENDED;
					pfsm_pkg::CMD_FAIL:  play = pfsm_pkg::PBC_FAILED;
					pfsm_pkg::CMD_RDREADY: begin
						reader = pfsm_pkg::RDC_READY;
						fault  = pfsm_pkg::ERR_NONE;
					end
					pfsm_pkg::CMD_RDBEGIN: begin
						reader = pfsm_pkg::RDC_READING;
						fault  = pfsm_pkg::ERR_NONE;
					end
					pfsm_pkg::CMD_RDCOMPLETE: begin
						reader = pfsm_pkg::RDC_COMPLETED;
						fault  = pfsm_pkg::ERR_NONE;
					end
					pfsm_pkg::CMD_RDFAIL: begin
						reader = pfsm_pkg::RDC_FAILED;
						fault  = (code == pfsm_pkg::ERR_NONE) ? pfsm_pkg::ERR_UNKNOWN : code;
					end
					pfsm_pkg::CMD_CANCEL: begin
						reader = pfsm_pkg::RDC_CANCELLED;
						fault  = pfsm_pkg::ERR_CANCELLED;
					end
					pfsm_pkg::CMD_LOOP: begin
						iter_cnt++;
						reader = pfsm_pkg::RDC_READY;
						fault  = pfsm_pkg::ERR_NONE;
					end
					default: ;
				endcase
			end
			s                  = '0;
			s.accepted         = ok;
			s.playback_state   = play;
			s.reader_state     = reader;
			s.reader_error     = fault;
			s.media_present    = media;
			s.loop_allowed     = media && reader == pfsm_pkg::RDC_COMPLETED;
			s.frame_sequence   = seq_cnt;
			s.media_generation = gen_cnt;
			s.timeline_epoch   = epoch_cnt;
			s.loop_count       = iter_cnt;
			if (cmd == pfsm_pkg::CMD_FRAMETAG)
				seq_cnt++;
			status_due.push_back(s);
		endfunction

		function void flag(string what, logic [CB-1:0] want, logic [CB-1:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %0h, got %0h", what, want, got);
			end
		endfunction

		function void match_status(logic [OUT_W-1:0] data);
			frame_status_t want;
			frame_status_t got;
			got = frame_status_t'(data[ST_W-1:0]);
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no event waiting: %0h", data);
				return;
			end
			want = status_due.pop_front();
			compared++;
			flag("accepted", want.accepted, got.accepted);
			flag("playback_state", want.playback_state, got.playback_state);
			flag("reader_state", want.reader_state, got.reader_state);
			flag("reader_error", want.reader_error, got.reader_error);
			flag("media_present", want.media_present, got.media_present);
			flag("loop_allowed", want.loop_allowed, got.loop_allowed);
			flag("frame_sequence", want.frame_sequence, got.frame_sequence);
			flag("media_generation", want.media_generation, got.media_generation);
			flag("timeline_epoch", want.timeline_epoch, got.timeline_epoch);
			flag("loop_count", want.loop_count, got.loop_count);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	bit               calm;

	playback_tracker board;

	playback_frame_state_machine_core #(
		.COUNTER_BITS(CB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send(input logic [3:0] cmd, input logic [3:0] code);
		int gap;
		bit done;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {code, cmd};
		done     = 1'b0;
		while (!done) begin
			@(posedge clk);
			if (s_tready) begin
				done = 1'b1;
				board.take_event(cmd, code);
			end
			@(negedge clk);
		end
	endtask

	// favor events that move the machines on over ones that reset them
	task automatic pick_event(output logic [3:0] cmd);
		int tries;
		cmd = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) < 8) begin
			for (tries = 0; tries < 10; tries++) begin
				if (board.allows(cmd) && ((cmd != pfsm_pkg::CMD_SELECT &&
					cmd != pfsm_pkg::CMD_FAIL && cmd != pfsm_pkg::CMD_RDFAIL &&
					cmd != pfsm_pkg::CMD_CANCEL) || $urandom_range(0, 3) == 0))
					break;
				cmd = 4'($urandom_range(0, 15));
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (board.status_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int          n;
		logic [3:0]  cmd;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		calm     = 1'b0;
		board    = new();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(pfsm_pkg::CMD_START, ERR_TOP);
		send(pfsm_pkg::CMD_PAUSE, pfsm_pkg::ERR_NONE);
		send(pfsm_pkg::CMD_RESUME, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_SEEK, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_ENDED, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDBEGIN, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDCOMPLETE, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_LOOP, 4'($urandom_range(0, 15)));
		send(CMD_UNUSED_LO, pfsm_pkg::ERR_NONE);
		send(CMD_UNUSED_HI, ERR_TOP);
		send(pfsm_pkg::CMD_FRAMETAG, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_SELECT, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDREADY, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDBEGIN, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDCOMPLETE, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_LOOP, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_START, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_FRAMETAG, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_PAUSE, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RESUME, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_ENDED, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_SEEK, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_START, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_FAIL, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_SEEK, 4'($urandom_range(0, 15)));
		send(pfsm_pkg::CMD_RDFAIL, pfsm_pkg::ERR_NONE);
		send(pfsm_pkg::CMD_RDFAIL, ERR_TOP);
		send(pfsm_pkg::CMD_CANCEL, 4'($urandom_range(0, 15)));

		for (n = 0; n < RUN_ITEMS; n++) begin
			calm = ((n / 100) % 3) == 2;
			if (n == RUN_ITEMS / 2)
				wait_drained();
			pick_event(cmd);
			send(cmd, 4'($urandom_range(0, 15)));
		end

		calm = 1'b0;
		wait_drained();
		repeat (8) @(negedge clk);

		$display("run covered %0d events, %0d accepted, %0d results compared, %0d mismatches",
			board.taken, board.granted, board.compared, board.mismatches);
		$display("counters reached: generation %0d, epoch %0d, loop iterations %0d",
			board.gen_cnt, board.epoch_cnt, board.iter_cnt);
		if (board.mismatches == 0 && board.status_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int stall;
		bit got;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			got      = 1'b0;
			while (!got) begin
				@(posedge clk);
				if (m_tvalid) begin
					got = 1'b1;
					board.match_status(m_tdata);
				end
				@(negedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", idle);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule

### files.f
hdl/pfsm_pkg.sv
hdl/pfsm_engine.sv
hdl/playback_frame_state_machine_core.sv
tb/playback_frame_state_machine_core_test.sv
